// ===== design/swiglu_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and elaboration-time functions of the SwiGLU matrix-vector core.
package swiglu_pkg;

    localparam int MAX_MODEL_DIM_DEF   = 1024;
    localparam int MAX_FFN_DIM_DEF     = 8192;
    localparam int SIGMOID_ENTRIES_DEF = 1024;

    localparam int KIND_W = 3;
    localparam int VAL_W  = 16;
    localparam int OIDX_W = 10;
    localparam int MDIM_W = 11;
    localparam int FDIM_W = 14;
    localparam int CFG_W  = 14;
    localparam int CIDX_W = 1;
    localparam int ACC_W  = 48;
    localparam int SIG_W  = 13;
    localparam int SIG_MAX = 4096;
    localparam int SIG_AW  = 12;

    localparam logic [63:0] EXP_STEP = 64'd4293918848;

    localparam logic [KIND_W-1:0] KIND_INPUT = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GU_W  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_GU_B  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DN_W  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_DN_B  = 3'd4;

    localparam logic [CIDX_W-1:0] REG_MODEL_DIM = 1'b0;
    localparam logic [CIDX_W-1:0] REG_FFN_DIM   = 1'b1;

    typedef struct packed {
        logic accept;
        logic mul;
        logic acc;
        logic sig;
        logic gs;
        logic silu;
        logic pu;
        logic wr;
    } t_cmd;

    typedef struct packed {
        logic is_mac;
        logic is_bias;
        logic hold;
    } t_status;

    typedef logic [SIG_W-1:0] t_sig_tab [SIG_MAX];

    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int k = 63; k >= 0; k--) begin
            rem = {rem[63:0], num[k]};
            if (rem >= {1'b0, den}) begin
                rem = rem - {1'b0, den};
                quo[k] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [SIG_W-1:0] sig_pos(input logic [95:0] e);
        logic [63:0] d;
        logic [63:0] num;
        d = (64'd1 << 32) + e[63:0];
        num = (64'd1 << 44) + (d >> 1);
        return SIG_W'(udiv(num, d));
    endfunction

    function automatic t_sig_tab sig_table(input int n);
        t_sig_tab t;
        logic [95:0] e;
        int u;
        int z;
        t = '{default: '0};
        e = 96'd1 << 32;
        u = 0;
        for (int i = 0; i < n; i++) begin
            z = int'(udiv(64'(i) * 64'd65536, 64'(n))) - 32768;
            if (z >= 0) begin
                while (u < z) begin
                    e = ((e * 96'(EXP_STEP)) + (96'd1 << 31)) >> 32;
                    u++;
                end
                t[i] = sig_pos(e);
            end
        end
        e = 96'd1 << 32;
        u = 0;
        for (int i = n; i > 0; i--) begin
            z = int'(udiv(64'(i - 1) * 64'd65536, 64'(n))) - 32768;
            if (z < 0) begin
                while (u < -z) begin
                    e = ((e * 96'(EXP_STEP)) + (96'd1 << 31)) >> 32;
                    u++;
                end
                t[i - 1] = SIG_W'(13'd4096 - sig_pos(e));
            end
        end
        return t;
    endfunction

    // Q8.24 to Q4.12: round half up, saturate to 16 bits.
    function automatic logic signed [VAL_W-1:0] conv(input logic signed [49:0] v);
        logic signed [49:0] w;
        logic signed [49:0] q;
        w = v + 50'sd2048;
        q = w >>> 12;
        if (q > 50'sd32767) begin
            return 16'sh7FFF;
        end else if (q < -50'sd32768) begin
            return 16'sh8000;
        end
        return q[VAL_W-1:0];
    endfunction

endpackage

// ===== design/swiglu_in_if.sv =====
`timescale 1ns / 1ps
// Input word channel of the SwiGLU core.
interface swiglu_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [swiglu_pkg::KIND_W-1:0]          kind;
    logic signed [swiglu_pkg::VAL_W-1:0]    first_value;
    logic signed [swiglu_pkg::VAL_W-1:0]    second_value;

    modport source(output valid, kind, first_value, second_value, input ready);
    modport sink(input valid, kind, first_value, second_value, output ready);
endinterface

// ===== design/swiglu_out_if.sv =====
`timescale 1ns / 1ps
// Output word channel of the SwiGLU core.
interface swiglu_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [swiglu_pkg::VAL_W-1:0]    output_value;
    logic [swiglu_pkg::OIDX_W-1:0]          output_index;
    logic                                   last_output;

    modport source(output valid, output_value, output_index, last_output, input ready);
    modport sink(input valid, output_value, output_index, last_output, output ready);
endinterface

// ===== design/swiglu_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module swiglu_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== design/swiglu_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine that sequences each accepted word through the datapath.
module swiglu_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  swiglu_pkg::t_status i_status,
    output swiglu_pkg::t_cmd    o_cmd
);
    typedef enum logic [2:0] {
        ST_IDLE, ST_MUL, ST_ACC, ST_SIG, ST_GS, ST_SILU, ST_PU, ST_WR
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   ready;
    logic   accept;

    assign ready  = (r_state == ST_IDLE) && !i_status.hold;
    assign accept = i_valid && ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && i_status.is_mac) begin
                    n_state = ST_MUL;
                end else if (accept && i_status.is_bias) begin
                    n_state = ST_SIG;
                end
            end
            ST_MUL:  n_state = ST_ACC;
            ST_ACC:  n_state = ST_IDLE;
            ST_SIG:  n_state = ST_GS;
            ST_GS:   n_state = ST_SILU;
            ST_SILU: n_state = ST_PU;
            ST_PU:   n_state = ST_WR;
            ST_WR:   n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ready     = ready;
    assign o_cmd.accept = accept;
    assign o_cmd.mul   = (r_state == ST_MUL);
    assign o_cmd.acc   = (r_state == ST_ACC);
    assign o_cmd.sig   = (r_state == ST_SIG);
    assign o_cmd.gs    = (r_state == ST_GS);
    assign o_cmd.silu  = (r_state == ST_SILU);
    assign o_cmd.pu    = (r_state == ST_PU);
    assign o_cmd.wr    = (r_state == ST_WR);

`ifndef NO_ASSERTIONS
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ready |-> r_state == ST_IDLE) else $error("ready outside idle");
    a_wr_after_pu: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_WR |-> $past(r_state) == ST_PU) else $error("bad write sequence");
    a_mac_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_status.is_mac |=> r_state == ST_MUL) else $error("mac not started");
`endif
endmodule

// ===== design/swiglu_dp.sv =====
`timescale 1ns / 1ps
// Datapath: counters, stores, accumulators, sigmoid lookup and the output register.
module swiglu_dp #(
    parameter int MAX_MODEL_DIM   = swiglu_pkg::MAX_MODEL_DIM_DEF,
    parameter int MAX_FFN_DIM     = swiglu_pkg::MAX_FFN_DIM_DEF,
    parameter int SIGMOID_ENTRIES = swiglu_pkg::SIGMOID_ENTRIES_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  swiglu_pkg::t_cmd                    i_cmd,
    output swiglu_pkg::t_status                 o_status,
    input  logic [swiglu_pkg::KIND_W-1:0]       i_kind,
    input  logic signed [swiglu_pkg::VAL_W-1:0] i_first,
    input  logic signed [swiglu_pkg::VAL_W-1:0] i_second,
    input  logic                                i_cfg_we,
    input  logic [swiglu_pkg::CIDX_W-1:0]       i_cfg_idx,
    input  logic [swiglu_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic signed [swiglu_pkg::VAL_W-1:0] o_output_value,
    output logic [swiglu_pkg::OIDX_W-1:0]       o_output_index,
    output logic                                o_last_output
);
    localparam int MW  = $clog2(MAX_MODEL_DIM + 1);
    localparam int FW  = $clog2(MAX_FFN_DIM + 1);
    localparam int CW  = (MW > FW) ? MW : FW;
    localparam int XAW = $clog2(MAX_MODEL_DIM);
    localparam int HAW = $clog2(MAX_FFN_DIM);
    localparam int SAW = $clog2(SIGMOID_ENTRIES);
    localparam int MD_RST = (1024 > MAX_MODEL_DIM) ? MAX_MODEL_DIM : 1024;
    localparam int FD_RST = (4096 > MAX_FFN_DIM) ? MAX_FFN_DIM : 4096;
    localparam swiglu_pkg::t_sig_tab SIG_TAB = swiglu_pkg::sig_table(SIGMOID_ENTRIES);

    logic [MW-1:0]                        r_md;
    logic [FW-1:0]                        r_fd;
    logic [CW-1:0]                        r_col;
    logic [CW-1:0]                        r_row;
    logic signed [swiglu_pkg::ACC_W-1:0]  r_gacc;
    logic signed [swiglu_pkg::ACC_W-1:0]  r_uacc;
    logic signed [swiglu_pkg::ACC_W-1:0]  r_dacc;
    logic                                 r_ovalid;
    logic signed [swiglu_pkg::VAL_W-1:0]  r_a;
    logic signed [swiglu_pkg::VAL_W-1:0]  r_b;
    logic [swiglu_pkg::KIND_W-1:0]        r_kind;
    logic signed [swiglu_pkg::VAL_W-1:0]  r_g;
    logic signed [swiglu_pkg::VAL_W-1:0]  r_u;
    logic signed [swiglu_pkg::VAL_W-1:0]  r_silu;
    logic [swiglu_pkg::SIG_W-1:0]         r_s;
    logic signed [31:0]                   r_p1;
    logic signed [31:0]                   r_p2;
    logic [HAW-1:0]                       r_widx;
    logic signed [swiglu_pkg::VAL_W-1:0]  r_oval;
    logic [swiglu_pkg::OIDX_W-1:0]        r_oidx;
    logic                                 r_olast;

    logic [CW-1:0]          md_c;
    logic [CW-1:0]          fd_c;
    logic [CW-1:0]          colm;
    logic [CW-1:0]          colf;
    logic [CW-1:0]          rowm;
    logic [CW-1:0]          rowf;
    logic [CW-1:0]          colm_nx;
    logic [CW-1:0]          colf_nx;
    logic [CW-1:0]          rowm_nx;
    logic [CW-1:0]          rowf_nx;
    logic [swiglu_pkg::VAL_W-1:0] x_rdata;
    logic [swiglu_pkg::VAL_W-1:0] h_rdata;
    logic [swiglu_pkg::VAL_W-1:0] h_wdata;
    logic                   x_we;
    logic signed [49:0]     gsum;
    logic signed [49:0]     usum;
    logic signed [49:0]     dsum;
    logic [15:0]            gu;
    logic [31:0]            sprod;
    logic [SAW-1:0]         sidx;
    logic [MW:0]            cfg_md;
    logic [FW:0]            cfg_fd;

    assign md_c = CW'(r_md);
    assign fd_c = CW'(r_fd);
    assign colm = (r_col >= md_c) ? '0 : r_col;
    assign colf = (r_col >= fd_c) ? '0 : r_col;
    assign rowm = (r_row >= md_c) ? '0 : r_row;
    assign rowf = (r_row >= fd_c) ? '0 : r_row;
    assign colm_nx = ({1'b0, colm} + 1'b1 >= {1'b0, md_c}) ? '0 : colm + 1'b1;
    assign colf_nx = ({1'b0, colf} + 1'b1 >= {1'b0, fd_c}) ? '0 : colf + 1'b1;
    assign rowm_nx = ({1'b0, rowm} + 1'b1 >= {1'b0, md_c}) ? '0 : rowm + 1'b1;
    assign rowf_nx = ({1'b0, rowf} + 1'b1 >= {1'b0, fd_c}) ? '0 : rowf + 1'b1;

    assign gsum = 50'(r_gacc) + (50'(i_first) <<< 12);
    assign usum = 50'(r_uacc) + (50'(i_second) <<< 12);
    assign dsum = 50'(r_dacc) + (50'(i_first) <<< 12);

    assign gu    = {~r_g[15], r_g[14:0]};
    assign sprod = 32'(gu) * 32'(SIGMOID_ENTRIES);
    assign sidx  = sprod[16 +: SAW];

    assign x_we    = i_cmd.accept && (i_kind == swiglu_pkg::KIND_INPUT);
    assign h_wdata = swiglu_pkg::conv(50'(r_p1));

    swiglu_ram #(.WIDTH(swiglu_pkg::VAL_W), .DEPTH(MAX_MODEL_DIM)) u_xram (
        .i_clk   (i_clk),
        .i_we    (x_we),
        .i_waddr (colm[XAW-1:0]),
        .i_wdata (i_first),
        .i_raddr (colm[XAW-1:0]),
        .o_rdata (x_rdata)
    );

    swiglu_ram #(.WIDTH(swiglu_pkg::VAL_W), .DEPTH(MAX_FFN_DIM)) u_hram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr),
        .i_waddr (r_widx),
        .i_wdata (h_wdata),
        .i_raddr (colf[HAW-1:0]),
        .o_rdata (h_rdata)
    );

    assign o_status.is_mac  = (i_kind == swiglu_pkg::KIND_GU_W) ||
                              (i_kind == swiglu_pkg::KIND_DN_W);
    assign o_status.is_bias = (i_kind == swiglu_pkg::KIND_GU_B);
    assign o_status.hold    = (i_kind == swiglu_pkg::KIND_DN_B) && r_ovalid && !i_out_ready;

    assign cfg_md = (i_cfg_data[swiglu_pkg::MDIM_W-1:0] == '0) ? (MW+1)'(1) :
                    (32'(i_cfg_data[swiglu_pkg::MDIM_W-1:0]) > MAX_MODEL_DIM) ?
                    (MW+1)'(MAX_MODEL_DIM) : (MW+1)'(i_cfg_data[swiglu_pkg::MDIM_W-1:0]);
    assign cfg_fd = (i_cfg_data[swiglu_pkg::FDIM_W-1:0] == '0) ? (FW+1)'(1) :
                    (32'(i_cfg_data[swiglu_pkg::FDIM_W-1:0]) > MAX_FFN_DIM) ?
                    (FW+1)'(MAX_FFN_DIM) : (FW+1)'(i_cfg_data[swiglu_pkg::FDIM_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_md     <= MW'(MD_RST);
            r_fd     <= FW'(FD_RST);
            r_col    <= '0;
            r_row    <= '0;
            r_gacc   <= '0;
            r_uacc   <= '0;
            r_dacc   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we && i_cfg_idx == swiglu_pkg::REG_MODEL_DIM) begin
                r_md <= cfg_md[MW-1:0];
            end
            if (i_cfg_we && i_cfg_idx == swiglu_pkg::REG_FFN_DIM) begin
                r_fd <= cfg_fd[FW-1:0];
            end
            if (r_ovalid && i_out_ready) begin
                r_ovalid <= 1'b0;
            end
            if (i_cmd.accept) begin
                case (i_kind)
                    swiglu_pkg::KIND_INPUT, swiglu_pkg::KIND_GU_W: begin
                        r_col <= colm_nx;
                    end
                    swiglu_pkg::KIND_GU_B: begin
                        r_row  <= rowf_nx;
                        r_col  <= '0;
                        r_gacc <= '0;
                        r_uacc <= '0;
                    end
                    swiglu_pkg::KIND_DN_W: begin
                        r_col <= colf_nx;
                    end
                    swiglu_pkg::KIND_DN_B: begin
                        r_row    <= rowm_nx;
                        r_col    <= '0;
                        r_dacc   <= '0;
                        r_ovalid <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cmd.acc) begin
                if (r_kind == swiglu_pkg::KIND_GU_W) begin
                    r_gacc <= r_gacc + 48'(r_p1);
                    r_uacc <= r_uacc + 48'(r_p2);
                end else begin
                    r_dacc <= r_dacc + 48'(r_p1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_a    <= i_first;
            r_b    <= i_second;
            r_kind <= i_kind;
            if (i_kind == swiglu_pkg::KIND_GU_B) begin
                r_g    <= swiglu_pkg::conv(gsum);
                r_u    <= swiglu_pkg::conv(usum);
                r_widx <= rowf[HAW-1:0];
            end
            if (i_kind == swiglu_pkg::KIND_DN_B) begin
                r_oval  <= swiglu_pkg::conv(dsum);
                r_oidx  <= swiglu_pkg::OIDX_W'(rowm);
                r_olast <= (rowm == md_c - 1'b1);
            end
        end
        if (i_cmd.mul) begin
            if (r_kind == swiglu_pkg::KIND_GU_W) begin
                r_p1 <= 32'($signed(x_rdata)) * 32'(r_a);
                r_p2 <= 32'($signed(x_rdata)) * 32'(r_b);
            end else begin
                r_p1 <= 32'($signed(h_rdata)) * 32'(r_a);
            end
        end
        if (i_cmd.sig) begin
            r_s <= SIG_TAB[swiglu_pkg::SIG_AW'(sidx)];
        end
        if (i_cmd.gs) begin
            r_p1 <= 32'(r_g) * 32'($signed({1'b0, r_s}));
        end
        if (i_cmd.silu) begin
            r_silu <= swiglu_pkg::conv(50'(r_p1));
        end
        if (i_cmd.pu) begin
            r_p1 <= 32'(r_silu) * 32'(r_u);
        end
    end

    assign o_out_valid    = r_ovalid;
    assign o_output_value = r_oval;
    assign o_output_index = r_oidx;
    assign o_last_output  = r_olast;

`ifndef NO_ASSERTIONS
    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && i_kind == swiglu_pkg::KIND_DN_B |=> r_ovalid)
        else $error("output word not loaded");
    a_dims_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_md != '0 && r_fd != '0) else $error("zero dimension");
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.accept && i_kind == swiglu_pkg::KIND_DN_B |-> !r_ovalid || i_out_ready)
        else $error("pending output overwritten");
`endif
endmodule

// ===== design/swiglu_mlp_matvec_core.sv =====
`timescale 1ns / 1ps
// Top level of the SwiGLU gated feed-forward matrix-vector core.
// Usage: words enter on i_in (kind, first_value, second_value) with valid/ready.
// Kind 0 stores input elements, kind 1 accumulates gate/up weight pairs, kind 2
// closes a hidden row, kind 3 accumulates down weights, kind 4 closes an output
// row and produces one word on o_out (value, index, last flag).
// Dimensions are written through i_cfg_we/i_cfg_idx/i_cfg_data; the user must
// do so only while idle, which the core does not enforce. Kinds 0, 4 and unused
// codes finish on accept; kinds 1 and 3 go through store read, multiply and
// accumulate, kind 2 through convert, sigmoid lookup and two multiplies each
// followed by a conversion; no new word is taken until these are through.
// A kind 4 result appears on o_out the cycle after accept.
// The output register lets other words proceed while a result waits; a new
// kind 4 word is held off only while a previous result is still unaccepted.
// Reset is synchronous and active low: counters, accumulators and dimension
// registers return to defaults; the stores keep their contents and no
// clearing pass is run.
module swiglu_mlp_matvec_core #(
    parameter int MAX_MODEL_DIM   = swiglu_pkg::MAX_MODEL_DIM_DEF,
    parameter int MAX_FFN_DIM     = swiglu_pkg::MAX_FFN_DIM_DEF,
    parameter int SIGMOID_ENTRIES = swiglu_pkg::SIGMOID_ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    swiglu_in_if.sink                     i_in,
    swiglu_out_if.source                  o_out,
    input  logic                          i_cfg_we,
    input  logic [swiglu_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [swiglu_pkg::CFG_W-1:0]  i_cfg_data
);
    swiglu_pkg::t_cmd    cmd;
    swiglu_pkg::t_status status;

    swiglu_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_in.valid),
        .o_ready  (i_in.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    swiglu_dp #(
        .MAX_MODEL_DIM   (MAX_MODEL_DIM),
        .MAX_FFN_DIM     (MAX_FFN_DIM),
        .SIGMOID_ENTRIES (SIGMOID_ENTRIES)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_kind         (i_in.kind),
        .i_first        (i_in.first_value),
        .i_second       (i_in.second_value),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (o_out.ready),
        .o_out_valid    (o_out.valid),
        .o_output_value (o_out.output_value),
        .o_output_index (o_out.output_index),
        .o_last_output  (o_out.last_output)
    );
endmodule

// ===== tb/sv/swiglu_ffn_checker.sv =====
`timescale 1ns / 1ps
// Checker for the SwiGLU core: it watches both word channels and the register port and compares results.
module swiglu_ffn_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    swiglu_in_if                          i_in,
    swiglu_out_if                         i_out,
    input  logic                          i_cfg_we,
    input  logic [swiglu_pkg::CIDX_W-1:0] i_cfg_idx,
    input  logic [swiglu_pkg::CFG_W-1:0]  i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import swiglu_pkg::*;

    localparam int MDIM_MAX = 1024;
    localparam int FDIM_MAX = 8192;
    localparam int SIG_N    = 1024;

    typedef struct {
        logic signed [VAL_W-1:0] value;
        logic [OIDX_W-1:0]       index;
        logic                    last;
    } t_out_word;

    t_out_word               out_words_due[$];
    logic signed [VAL_W-1:0] x_vec [MDIM_MAX];
    logic signed [VAL_W-1:0] h_vec [FDIM_MAX];
    logic [SIG_W-1:0]        sig_lut [SIG_N];
    logic signed [ACC_W-1:0] gate_sum, up_sum, down_sum;
    int                      col, row;
    logic [MDIM_W-1:0]       md_reg;
    logic [FDIM_W-1:0]       fd_reg;

    function automatic logic [SIG_W-1:0] logistic_pos(input logic [95:0] e);
        logic [95:0] d;
        d = (96'd1 << 32) + e;
        return SIG_W'(((96'd1 << 44) + (d >> 1)) / d);
    endfunction

    // Entries sit every 64 steps of z, so exp(-|z|) is walked once in 64-step hops.
    initial begin
        logic [SIG_W-1:0] pos_val [513];
        logic [95:0]      e;
        int               z;
        e = 96'd1 << 32;
        for (int k = 0; k <= 512; k++) begin
            pos_val[k] = logistic_pos(e);
            for (int s = 0; s < 64; s++) begin
                e = (e * 96'(EXP_STEP) + (96'd1 << 31)) >> 32;
            end
        end
        for (int i = 0; i < SIG_N; i++) begin
            z = i * 64 - 32768;
            sig_lut[i] = (z >= 0) ? pos_val[z / 64] : SIG_W'(13'd4096 - pos_val[-z / 64]);
        end
    end

    function automatic logic signed [VAL_W-1:0] to_q12(input longint v);
        longint q;
        q = (v + 2048) >>> 12;
        if (q > 32767) begin
            return 16'sh7FFF;
        end else if (q < -32768) begin
            return 16'sh8000;
        end
        return VAL_W'(q);
    endfunction

    function automatic int eff_dim(input int v, input int lim);
        if (v == 0) begin
            return 1;
        end
        return (v > lim) ? lim : v;
    endfunction

    task automatic report(input string msg);
        $display("%0t ns mismatch: %s", $time, msg);
        o_fail_count++;
    endtask

    task automatic predict_word(input logic [KIND_W-1:0] kind,
                                input logic signed [VAL_W-1:0] a,
                                input logic signed [VAL_W-1:0] b);
        int                      md, fd, idx;
        logic signed [VAL_W-1:0] g, u, silu;
        t_out_word               w;
        md = eff_dim(int'(md_reg), MDIM_MAX);
        fd = eff_dim(int'(fd_reg), FDIM_MAX);
        case (kind)
            KIND_INPUT, KIND_GU_W: begin
                if (col >= md) col = 0;
                if (kind == KIND_INPUT) begin
                    x_vec[col] = a;
                end else begin
                    gate_sum = gate_sum + ACC_W'(longint'(x_vec[col]) * longint'(a));
                    up_sum   = up_sum + ACC_W'(longint'(x_vec[col]) * longint'(b));
                end
                col = (col + 1 >= md) ? 0 : col + 1;
            end
            KIND_GU_B: begin
                if (row >= fd) row = 0;
                g = to_q12(longint'(gate_sum) + longint'(a) * 4096);
                u = to_q12(longint'(up_sum) + longint'(b) * 4096);
                idx = ((int'(g) + 32768) * SIG_N) >> 16;
                silu = to_q12(longint'(g) * longint'(sig_lut[idx]));
                h_vec[row] = to_q12(longint'(silu) * longint'(u));
                row = (row + 1 >= fd) ? 0 : row + 1;
                gate_sum = '0;
                up_sum = '0;
                col = 0;
            end
            KIND_DN_W: begin
                if (col >= fd) col = 0;
                down_sum = down_sum + ACC_W'(longint'(h_vec[col]) * longint'(a));
                col = (col + 1 >= fd) ? 0 : col + 1;
            end
            KIND_DN_B: begin
                if (row >= md) row = 0;
                w.value = to_q12(longint'(down_sum) + longint'(a) * 4096);
                w.index = OIDX_W'(row);
                w.last  = (row == md - 1);
                out_words_due.push_back(w);
                row = (row + 1 >= md) ? 0 : row + 1;
                down_sum = '0;
                col = 0;
            end
            default: begin
            end
        endcase
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin
        t_out_word w;
        if (!i_rst_n) begin
            gate_sum = '0;
            up_sum = '0;
            down_sum = '0;
            col = 0;
            row = 0;
            md_reg = MDIM_W'(1024);
            fd_reg = FDIM_W'(4096);
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_MODEL_DIM) begin
                    md_reg = i_cfg_data[MDIM_W-1:0];
                end else if (i_cfg_idx == REG_FFN_DIM) begin
                    fd_reg = i_cfg_data[FDIM_W-1:0];
                end
            end
            if (i_in.valid && i_in.ready) begin
                predict_word(i_in.kind, i_in.first_value, i_in.second_value);
            end
            if (i_out.valid && i_out.ready) begin
                if (out_words_due.size() == 0) begin
                    report($sformatf("unexpected word value %0d index %0d",
                                     i_out.output_value, i_out.output_index));
                end else begin
                    w = out_words_due.pop_front();
                    if (i_out.output_value !== w.value) begin
                        report($sformatf("value %0d, predicted %0d (index %0d)",
                                         i_out.output_value, w.value, w.index));
                    end
                    if (i_out.output_index !== w.index) begin
                        report($sformatf("index %0d, predicted %0d",
                                         i_out.output_index, w.index));
                    end
                    if (i_out.last_output !== w.last) begin
                        report($sformatf("last flag %0b, predicted %0b (index %0d)",
                                         i_out.last_output, w.last, w.index));
                    end
                end
            end
        end
        o_pending = out_words_due.size();
    end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Top of the SwiGLU core testbench: clock, reset, word stimulus and the final verdict.
module testbench;
    import swiglu_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CIDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]  i_cfg_data;
    int                fail_count;
    int                pending;
    int                cycle_count;
    int                words_sent;
    bit                no_gaps;
    bit                long_hold;

    swiglu_in_if  in_ch();
    swiglu_out_if out_ch();

    swiglu_mlp_matvec_core u_dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (in_ch),
        .o_out     (out_ch),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    swiglu_ffn_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic logic signed [VAL_W-1:0] rnd_val();
        case ($urandom_range(0, 7))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return VAL_W'($urandom_range(0, 8191)) - 16'sd4096;
            default: return VAL_W'($urandom);
        endcase
    endfunction

    // The process sits just after the rising edge that took the previous word.
    task automatic send_word(input logic [KIND_W-1:0] kind,
                             input logic signed [VAL_W-1:0] a,
                             input logic signed [VAL_W-1:0] b);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        @(negedge i_clk);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.kind <= kind;
        in_ch.first_value <= a;
        in_ch.second_value <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_W'(value);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_dims(input int md, input int fd);
        wait_idle();
        write_reg(REG_MODEL_DIM, md);
        write_reg(REG_FFN_DIM, fd);
        @(posedge i_clk);
    endtask

    // One full token: inputs, gate/up rows, then down rows, with random values.
    task automatic run_token(input int md, input int fd);
        for (int c = 0; c < md; c++) send_word(KIND_INPUT, rnd_val(), rnd_val());
        for (int r = 0; r < fd; r++) begin
            for (int c = 0; c < md; c++) send_word(KIND_GU_W, rnd_val(), rnd_val());
            send_word(KIND_GU_B, rnd_val(), rnd_val());
        end
        for (int r = 0; r < md; r++) begin
            for (int c = 0; c < fd; c++) send_word(KIND_DN_W, rnd_val(), rnd_val());
            send_word(KIND_DN_B, rnd_val(), rnd_val());
        end
    endtask

    function automatic int eff(input int v, input int lim);
        if (v == 0) return 1;
        return (v > lim) ? lim : v;
    endfunction

    // Output side: a random stall before every word unless no_gaps is set, or one long hold on request.
    initial begin
        int gap;
        out_ch.ready = 1'b0;
        @(posedge i_clk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 6);
            if (long_hold) begin
                gap = 400;
                long_hold = 1'b0;
            end
            @(negedge i_clk);
            if (gap > 0) begin
                out_ch.ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            out_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!out_ch.valid);
        end
    end

    initial begin
        int md, fd, md_raw, fd_raw;
        cycle_count = 0;
        words_sent = 0;
        no_gaps = 1'b0;
        long_hold = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_MODEL_DIM;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.kind = KIND_INPUT;
        in_ch.first_value = '0;
        in_ch.second_value = '0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Write every store entry that the later small vectors can reach.
        set_dims(8, 8);
        run_token(8, 8);

        set_dims(3, 2);
        send_word(KIND_INPUT, 16'sh7FFF, 16'sh0000);
        send_word(KIND_INPUT, 16'sh8000, 16'sh7FFF);
        send_word(KIND_INPUT, 16'sh7FFF, 16'sh8000);
        for (int r = 0; r < 2; r++) begin
            send_word(KIND_GU_W, 16'sh7FFF, 16'sh8000);
            send_word(KIND_GU_W, 16'sh8000, 16'sh8000);
            send_word(KIND_GU_W, 16'sh7FFF, 16'sh7FFF);
            send_word(KIND_GU_B, r ? 16'sh8000 : 16'sh7FFF, 16'sh7FFF);
        end
        send_word(3'd5, 16'sh7FFF, 16'sh7FFF);
        send_word(3'd6, 16'sh8000, 16'sh0000);
        send_word(3'd7, 16'sh1234, 16'sh8000);
        for (int r = 0; r < 3; r++) begin
            send_word(KIND_DN_W, 16'sh7FFF, 16'sh0000);
            send_word(KIND_DN_W, 16'sh8000, 16'sh0000);
            send_word(KIND_DN_B, r == 1 ? 16'sh8000 : 16'sh7FFF, 16'sh0000);
        end

        for (int ph = 0; words_sent < 1800; ph++) begin
            case ($urandom_range(0, 5))
                0: md_raw = 0;
                1: md_raw = $urandom_range(0, 16383);
                default: md_raw = $urandom_range(1, 6);
            endcase
            case ($urandom_range(0, 5))
                0: fd_raw = 0;
                1: fd_raw = 16383 - $urandom_range(0, 1);
                default: fd_raw = $urandom_range(1, 6);
            endcase
            md = eff(md_raw & 16'h7FF, 1024);
            fd = eff(fd_raw, 8192);
            if (md > 8) md_raw = 6;
            if (fd > 8) fd_raw = 5;
            md = eff(md_raw & 16'h7FF, 1024);
            fd = eff(fd_raw, 8192);
            set_dims(md_raw, fd_raw);
            no_gaps = ($urandom_range(0, 3) == 0);
            if (ph == 3) begin
                long_hold = 1'b1;
                no_gaps = 1'b1;
                for (int k = 0; k < 12; k++) send_word(KIND_DN_B, rnd_val(), rnd_val());
            end
            for (int t = 0; t < 3; t++) begin
                if ($urandom_range(0, 4) == 0) begin
                    for (int k = 0; k < 8; k++) begin
                        send_word(KIND_W'($urandom_range(0, 7)), VAL_W'($urandom),
                                  VAL_W'($urandom));
                    end
                end else begin
                    run_token(md, fd);
                end
            end
            no_gaps = 1'b0;
        end

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
